// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the report queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== rtl/rqdo_pkg.sv =====
// ----------------------------------------------------------------------------
// Report queue package
// Sizes, command and status codes, payload types and address helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rqdo_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int REPORT_BYTES = 64;
  localparam int READ_MAX     = 64;
  localparam int SLOTS        = QUEUE_DEPTH + 1;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int POS_W    = $clog2(REPORT_BYTES + 1);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int RCNT_W   = 7;
  localparam int CMP_W    = (POS_W > RCNT_W) ? POS_W : RCNT_W;
  localparam int STORE_DEPTH = SLOTS * REPORT_BYTES;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] STAT_DATA      = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_ZERO      = 3'd2;
  localparam logic [2:0] STAT_CLEARED   = 3'd3;
  localparam logic [2:0] STAT_ACCEPTED  = 3'd4;
  localparam logic [2:0] STAT_ACC_DROP  = 3'd5;
  localparam logic [2:0] STAT_DISCARDED = 3'd6;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        data_byte;
    logic              last;
    logic              rx_error;
    logic [RCNT_W-1:0] read_count;
  } rqdo_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       out_last;
  } rqdo_out_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [POS_W-1:0]  pos);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(slot) * ADDR_W'(REPORT_BYTES) + ADDR_W'(pos);
    return a;
  endfunction

endpackage

// ===== rtl/rqdo_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rqdo_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/report_queue_drop_oldest_core.sv =====
// ----------------------------------------------------------------------------
// Report queue with drop-oldest overflow
// Push and clear results are registered and appear in the cycle after the
// transfer in. A read looks up the length and its first byte together,
// registers the length in ST_LEN, then streams bytes in ST_STREAM, one
// byte per cycle while the output does not stall. One push or clear is
// taken per cycle while the output does not stall; the input is stalled
// for the whole of a read. Reset clears the pointers and counters at once;
// the RAMs are left as they are, so no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module report_queue_drop_oldest_core
  import rqdo_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rqdo_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rqdo_out_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_STREAM
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  queued_q, queued_d;
  logic [POS_W-1:0]  rpos_q, rpos_d;
  logic [POS_W-1:0]  stg_len_q, stg_len_d;
  logic              stg_bad_q, stg_bad_d;
  logic [RCNT_W-1:0] count_q, count_d;
  logic [POS_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  remain_q, remain_d;
  logic              out_valid_q, out_valid_d;
  rqdo_out_t         out_q, out_d;

  logic              in_acc;
  logic              out_load;
  logic              bad_n;
  logic              stg_wr;
  logic [POS_W-1:0]  len_n;
  logic [RCNT_W-1:0] count_sat;
  logic [POS_W-1:0]  diff;
  logic [POS_W-1:0]  rpos_inc;

  logic              st_wr_en;
  logic [ADDR_W-1:0] st_wr_addr;
  logic              st_rd_en;
  logic [ADDR_W-1:0] st_rd_addr;
  logic [7:0]        st_rd_data;

  logic              ln_wr_en;
  logic              ln_rd_en;
  logic [POS_W-1:0]  ln_rd_data;

  // The output register is free, or is being emptied in this cycle.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign bad_n     = stg_bad_q || in_data_i.rx_error || (stg_len_q >= POS_W'(REPORT_BYTES));
  assign stg_wr    = !stg_bad_q && !in_data_i.rx_error && (stg_len_q < POS_W'(REPORT_BYTES));
  assign len_n     = stg_len_q + POS_W'(stg_wr);
  assign count_sat = (in_data_i.read_count > RCNT_W'(READ_MAX)) ?
                     RCNT_W'(READ_MAX) : in_data_i.read_count;
  assign diff      = ln_rd_data - rpos_q;
  assign rpos_inc  = rpos_q + POS_W'(1);

  assign st_wr_en   = in_acc && (in_data_i.command == CMD_PUSH) && stg_wr;
  assign st_wr_addr = store_addr(tail_q, stg_len_q);
  assign st_rd_addr = (state_q == ST_IDLE) ? store_addr(head_q, rpos_q)
                                           : store_addr(head_q, rpos_inc);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    queued_d    = queued_q;
    rpos_d      = rpos_q;
    stg_len_d   = stg_len_q;
    stg_bad_d   = stg_bad_q;
    count_d     = count_q;
    len_d       = len_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    st_rd_en    = 1'b0;
    ln_rd_en    = 1'b0;
    ln_wr_en    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.command)
            CMD_PUSH: begin
              stg_len_d = len_n;
              stg_bad_d = bad_n;
              if (in_data_i.last) begin
                stg_len_d    = '0;
                stg_bad_d    = 1'b0;
                out_valid_d  = 1'b1;
                out_d.out_byte = '0;
                out_d.out_last = 1'b1;
                if (bad_n || (len_n == '0)) begin
                  out_d.status = STAT_DISCARDED;
                end else begin
                  ln_wr_en = 1'b1;
                  tail_d   = next_slot(tail_q);
                  if (queued_q >= CNT_W'(QUEUE_DEPTH)) begin
                    // Full: the oldest report gives way, the count is unchanged.
                    head_d       = next_slot(head_q);
                    rpos_d       = '0;
                    out_d.status = STAT_ACC_DROP;
                  end else begin
                    queued_d     = queued_q + CNT_W'(1);
                    out_d.status = STAT_ACCEPTED;
                  end
                end
              end
            end
            CMD_READ: begin
              out_d.out_byte = '0;
              out_d.out_last = 1'b1;
              if (count_sat == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = STAT_ZERO;
              end else if (queued_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = STAT_EMPTY;
              end else begin
                count_d  = count_sat;
                ln_rd_en = 1'b1;
                st_rd_en = 1'b1;
                state_d  = ST_LEN;
              end
            end
            CMD_CLEAR: begin
              head_d       = tail_q;
              queued_d     = '0;
              rpos_d       = '0;
              out_valid_d  = 1'b1;
              out_d.status = STAT_CLEARED;
              out_d.out_byte = '0;
              out_d.out_last = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LEN: begin
        len_d = ln_rd_data;
        if (CMP_W'(diff) > CMP_W'(count_q)) begin
          remain_d = POS_W'(count_q);
        end else begin
          remain_d = diff;
        end
        state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (out_load) begin
          out_valid_d    = 1'b1;
          out_d.status   = STAT_DATA;
          out_d.out_byte = st_rd_data;
          out_d.out_last = (remain_q == POS_W'(1));
          rpos_d         = rpos_inc;
          remain_d       = remain_q - POS_W'(1);
          if (remain_q == POS_W'(1)) begin
            state_d = ST_IDLE;
            if (rpos_inc >= len_q) begin
              head_d   = next_slot(head_q);
              queued_d = queued_q - CNT_W'(1);
              rpos_d   = '0;
            end
          end else begin
            // Fetch the following byte while this one moves to the output.
            st_rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      queued_q    <= '0;
      rpos_q      <= '0;
      stg_len_q   <= '0;
      stg_bad_q   <= 1'b0;
      count_q     <= '0;
      len_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      queued_q    <= queued_d;
      rpos_q      <= rpos_d;
      stg_len_q   <= stg_len_d;
      stg_bad_q   <= stg_bad_d;
      count_q     <= count_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  rqdo_ram #(
    .Width (8),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (in_data_i.data_byte),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  rqdo_ram #(
    .Width (POS_W),
    .Depth (SLOTS)
  ) u_length (
    .clk_i     (clk_i),
    .wr_en_i   (ln_wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i (len_n),
    .rd_en_i   (ln_rd_en),
    .rd_addr_i (head_q),
    .rd_data_o (ln_rd_data)
  );

  `ASSERT_CLK(a_queue_bound, queued_q <= CNT_W'(QUEUE_DEPTH), "queue count above its depth")
  `ASSERT_IMPL(a_empty_ptrs, queued_q == '0, head_q == tail_q, "empty queue with split pointers")
  `ASSERT_IMPL(a_busy_stall, state_q != ST_IDLE, in_stall_o, "input taken during a read")
  `ASSERT_IMPL(a_read_has_data, state_q == ST_STREAM, queued_q != '0 && remain_q != '0,
               "streaming with nothing queued")

endmodule
